// ===== src/integer_to_ascii_radix_converter_defines.svh =====
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter: assertion macros
// Shared property forms for the port checker, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_CONVERTER_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CONVERTER_DEFINES_SVH

// same-cycle implication
`define I2A_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2A_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Types, constants and character helpers of the integer to ASCII converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

   localparam int VALUE_W     = 64;
   localparam int DIGIT_W     = 4;
   localparam int CELL_COUNT  = 22;
   localparam int HEX_DIGITS  = 16;
   localparam int OCT_BITS    = 3;
   localparam int CNT_W       = 6;
   localparam int REMAIN_W    = 5;
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;
   localparam logic [DIGIT_W-1:0] DEC_LIMIT  = 4'd10;
   localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

   typedef enum logic [1:0] {
      MODE_SDEC = 2'd0,
      MODE_UDEC = 2'd1,
      MODE_OCT  = 2'd2,
      MODE_HEX  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic shift;
   } cell_ctrl_type;

   function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d,
                                             input logic lower);
      logic [7:0] base;
      base = lower ? (CHAR_UPPER_A + CASE_OFFSET) : CHAR_UPPER_A;
      if (d < DEC_LIMIT) begin
         return CHAR_ZERO + {4'b0, d};
      end else begin
         return base + {4'b0, d - DEC_LIMIT};
      end
   endfunction

endpackage

// ===== src/integer_to_ascii_radix_converter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_converter
// Prints a 64-bit integer as ASCII text in signed/unsigned decimal, octal or
// hexadecimal, most significant character first.
//
// Usage:
//   req channel: tuser = mode, tdata = value, octal prefix, hex case flag.
//   rsp channel: one character per transfer, tlast on the final character.
//   One number is in flight at a time; req_tready is high only when idle.
//   Steps: the number is taken, then a bit-serial shift-and-add-3 conversion
//   of all 64 bits runs through a row of 22 digit cells for decimal modes
//   (none for octal/hex, which load the cells directly), then leading zero
//   cells are skipped (up to 21), then the characters (1 to 23) are emitted
//   while rsp is free.
//   Reset empties the output register and returns to idle.
//   A stall on rsp holds the current character and pauses the emission.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [i2a_pkg::REQ_TUSER_W-1:0]    req_tuser,  // func
   input  logic [i2a_pkg::REQ_TDATA_W-1:0]    req_tdata,  // value, octal_prefix, hex_lower
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [i2a_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // ascii_char
   output logic                               rsp_tlast
);
   import i2a_pkg::*;

   state_type               state_ff, state_in;
   logic [VALUE_W-1:0]      mag_ff, mag_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [REMAIN_W-1:0]     remain_ff, remain_in;
   logic                    neg_ff, neg_in;
   logic                    prefix_ff, prefix_in;
   logic                    lower_ff, lower_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;
   cell_ctrl_type           ctrl;
   logic                    out_free;

   func_type                req_func;
   logic [VALUE_W-1:0]      req_value;
   logic                    req_prefix;
   logic                    req_lower;
   logic [VALUE_W+1:0]      value_ext;

   logic [DIGIT_W-1:0]      digits    [CELL_COUNT];
   logic [DIGIT_W-1:0]      load_dig  [CELL_COUNT];
   logic                    carries   [CELL_COUNT];
   logic [DIGIT_W-1:0]      top_digit;

   assign req_func   = func_type'(req_tuser);
   assign req_value  = req_tdata[VALUE_W-1:0];
   assign req_prefix = req_tdata[VALUE_W];
   assign req_lower  = req_tdata[VALUE_W+1];
   assign value_ext  = {2'b00, req_value};
   assign top_digit  = digits[CELL_COUNT-1];

   // digit cells
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      logic [DIGIT_W-1:0] hex_dig;
      logic [DIGIT_W-1:0] shift_src;
      logic               bit_src;

      if (i < HEX_DIGITS) begin : g_hex
         assign hex_dig = value_ext[DIGIT_W*i +: DIGIT_W];
      end else begin : g_nohex
         assign hex_dig = '0;
      end

      if (i == 0) begin : g_first
         assign shift_src = '0;
         assign bit_src   = mag_ff[VALUE_W-1];
      end else begin : g_next
         assign shift_src = digits[i-1];
         assign bit_src   = carries[i-1];
      end

      always_comb begin
         case (req_func)
            MODE_HEX: load_dig[i] = hex_dig;
            MODE_OCT: load_dig[i] = {1'b0, value_ext[OCT_BITS*i +: OCT_BITS]};
            default:  load_dig[i] = '0;
         endcase
      end

      i2a_cell u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .load_digit     (load_dig[i]),
         .shift_in_digit (shift_src),
         .bit_in         (bit_src),
         .digit          (digits[i]),
         .bit_out        (carries[i])
      );
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      remain_in    = remain_ff;
      neg_in       = neg_ff;
      prefix_in    = prefix_ff;
      lower_in     = lower_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               neg_in    = (req_func == MODE_SDEC) && req_value[VALUE_W-1];
               mag_in    = neg_in ? (VALUE_W'(0) - req_value) : req_value;
               prefix_in = (req_func == MODE_OCT) && req_prefix && (req_value != '0);
               lower_in  = (req_func == MODE_HEX) && req_lower;
               remain_in = REMAIN_W'(CELL_COUNT);
               cnt_in    = '1;
               if (req_func == MODE_SDEC || req_func == MODE_UDEC) begin
                  state_in = ST_CONV;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_CONV: begin
            ctrl.dabble = 1'b1;
            mag_in      = {mag_ff[VALUE_W-2:0], 1'b0};
            cnt_in      = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && remain_ff > REMAIN_W'(1)) begin
               ctrl.shift = 1'b1;
               remain_in  = remain_ff - REMAIN_W'(1);
            end else if (neg_ff || prefix_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = neg_ff ? CHAR_MINUS : CHAR_ZERO;
               rsp_last_in  = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = digit_char(top_digit, lower_ff);
               rsp_last_in  = (remain_ff == REMAIN_W'(1));
               ctrl.shift   = 1'b1;
               remain_in    = remain_ff - REMAIN_W'(1);
               if (remain_ff == REMAIN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      cnt_ff      <= cnt_in;
      remain_ff   <= remain_in;
      neg_ff      <= neg_in;
      prefix_ff   <= prefix_in;
      lower_ff    <= lower_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== src/i2a_cell.sv =====
// ----------------------------------------------------------------------------
// i2a_cell
// One digit cell: parallel load, double-dabble step, or shift toward the top.
// ----------------------------------------------------------------------------
module i2a_cell (
   input  logic                           clock,
   input  i2a_pkg::cell_ctrl_type         ctrl,
   input  logic [i2a_pkg::DIGIT_W-1:0]    load_digit,
   input  logic [i2a_pkg::DIGIT_W-1:0]    shift_in_digit,
   input  logic                           bit_in,
   output logic [i2a_pkg::DIGIT_W-1:0]    digit,
   output logic                           bit_out
);
   import i2a_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   assign adj     = (digit_ff >= DABBLE_MIN) ? digit_ff + DABBLE_ADD : digit_ff;
   assign bit_out = adj[DIGIT_W-1];
   assign digit   = digit_ff;

   always_comb begin
      if (ctrl.load) begin
         digit_in = load_digit;
      end else if (ctrl.dabble) begin
         digit_in = {adj[DIGIT_W-2:0], bit_in};
      end else if (ctrl.shift) begin
         digit_in = shift_in_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// ===== src/i2a_checker.sv =====
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks of the integer to ASCII converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_converter_defines.svh"

module i2a_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [i2a_pkg::REQ_TUSER_W-1:0]    req_tuser,  // func
   input  logic [i2a_pkg::REQ_TDATA_W-1:0]    req_tdata,  // value, octal_prefix, hex_lower
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [i2a_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // ascii_char
   input  logic                               rsp_tlast
);
   import i2a_pkg::*;

   logic req_fire;
   logic char_ok;

   assign req_fire = req_tvalid && req_tready;
   assign char_ok  = (rsp_tdata >= CHAR_ZERO && rsp_tdata <= CHAR_NINE) ||
                     (rsp_tdata >= CHAR_UPPER_A && rsp_tdata <= CHAR_UPPER_F) ||
                     (rsp_tdata >= CHAR_LOWER_A && rsp_tdata <= CHAR_LOWER_F) ||
                     (rsp_tdata == CHAR_MINUS);

   `I2A_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp changed while stalled")
   `I2A_ASSERT_NEXT(a_busy_after_take, req_fire, !req_tready, "new number taken while busy")
   `I2A_ASSERT_SAME(a_minus_not_last, rsp_tvalid && rsp_tdata == CHAR_MINUS, !rsp_tlast, "minus sign marked last")
   `I2A_ASSERT_SAME(a_char_set, rsp_tvalid, char_ok, "character outside digit set")

endmodule

bind integer_to_ascii_radix_converter i2a_checker u_i2a_checker (.*);

// ===== verif/tb_integer_to_ascii_radix_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_converter
// Sends 64-bit numbers in every conversion mode and checks each character
// against the text that a behavioral formatter predicts: corner values first,
// then random numbers under changing back-pressure and gaps on both sides.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix_converter;
   import i2a_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 150;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TUSER_W-1:0] req_tuser;  // func
   logic [REQ_TDATA_W-1:0] req_tdata;  // value, octal_prefix, hex_lower
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // ascii_char
   logic                   rsp_tlast;

   text_char_type pending_chars[$];
   int            send_idle_pct;
   int            recv_idle_pct;
   int            error_count;
   int            chars_checked;
   int            numbers_sent;
   int            mode_count[4];
   int            stall_cycles;

   integer_to_ascii_radix_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // format one number and queue its characters, most significant first
   function automatic void predict_text(func_type mode, logic [63:0] value,
                                        logic prefix, logic lower);
      logic [7:0]    text[$];
      logic [63:0]   mag;
      logic [63:0]   radix;
      logic [63:0]   digit;
      logic          neg;
      text_char_type entry;
      neg = (mode == MODE_SDEC) && value[63];
      mag = neg ? (64'd0 - value) : value;
      case (mode)
         MODE_OCT: radix = 64'd8;
         MODE_HEX: radix = 64'd16;
         default:  radix = 64'd10;
      endcase
      do begin
         digit = mag % radix;
         mag   = mag / radix;
         if (digit < 64'd10) begin
            text.push_front(CHAR_ZERO + digit[7:0]);
         end else begin
            text.push_front(CHAR_UPPER_A + (lower ? CASE_OFFSET : 8'd0) + digit[7:0] - 8'd10);
         end
      end while (mag != 64'd0 && text.size() < CELL_COUNT);
      if (mode == MODE_OCT && prefix && text[0] != CHAR_ZERO) begin
         text.push_front(CHAR_ZERO);
      end
      if (neg) begin
         text.push_front(CHAR_MINUS);
      end
      foreach (text[i]) begin
         entry.ch   = text[i];
         entry.last = (i == text.size() - 1);
         pending_chars.push_back(entry);
      end
   endfunction

   // drive one number and hold it until the transfer
   task automatic send_number(func_type mode, logic [63:0] value, logic prefix,
                              logic lower);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'b0, lower, prefix, value};
      do @(posedge clock); while (!req_tready);
      predict_text(mode, value, prefix, lower);
      numbers_sent++;
      mode_count[mode]++;
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(3))
         0: v = v;
         1: v = v >> $urandom_range(63);
         2: v = 64'd0 - (v >> $urandom_range(63, 30));
         default: v = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
      endcase
      return v;
   endfunction

   task automatic test_corner_values();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_number(MODE_SDEC, 64'd0, 1'b1, 1'b1);
      send_number(MODE_UDEC, 64'd0, 1'b0, 1'b0);
      send_number(MODE_OCT,  64'd0, 1'b0, 1'b0);
      send_number(MODE_OCT,  64'd0, 1'b1, 1'b0);
      send_number(MODE_HEX,  64'd0, 1'b0, 1'b1);
      send_number(MODE_SDEC, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
      send_number(MODE_SDEC, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0);
      send_number(MODE_SDEC, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
      send_number(MODE_SDEC, 64'd1, 1'b1, 1'b1);
      send_number(MODE_UDEC, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1);
      send_number(MODE_UDEC, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
      send_number(MODE_UDEC, 64'd9, 1'b0, 1'b0);
      send_number(MODE_UDEC, 64'd10, 1'b0, 1'b0);
      send_number(MODE_OCT,  64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);
      send_number(MODE_OCT,  64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);
      send_number(MODE_OCT,  64'd7, 1'b1, 1'b0);
      send_number(MODE_OCT,  64'd8, 1'b0, 1'b0);
      send_number(MODE_HEX,  64'hfedc_ba98_7654_3210, 1'b0, 1'b0);
      send_number(MODE_HEX,  64'hfedc_ba98_7654_3210, 1'b1, 1'b0);
      send_number(MODE_HEX,  64'habcd_ef01_2345_6789, 1'b1, 1'b1);
      send_number(MODE_HEX,  64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);
      send_number(MODE_HEX,  64'd15, 1'b0, 1'b1);
      send_number(MODE_HEX,  64'd16, 1'b0, 1'b0);
   endtask

   task automatic test_random_numbers(int s_pct, int r_pct, int count);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) begin
         send_number(func_type'($urandom_range(3)), random_value(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   // hold the sender until every character of the previous number is out
   task automatic test_drain_between_numbers(int count);
      send_idle_pct = 10;
      recv_idle_pct = 30;
      repeat (count) begin
         send_number(func_type'($urandom_range(3)), random_value(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
         req_tvalid <= 1'b0;
         while (pending_chars.size() != 0) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         chars_checked++;
         if (pending_chars.size() == 0) begin
            error_count++;
            $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata !== want.ch) begin
               error_count++;
               $display("%0t: ascii_char mismatch: expected 0x%02h, actual 0x%02h",
                        $time, want.ch, rsp_tdata);
            end
            if (rsp_tlast !== want.last) begin
               error_count++;
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      error_count   = 0;
      chars_checked = 0;
      numbers_sent  = 0;
      mode_count    = '{default: 0};
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_cycles  <= 0;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tuser     <= '0;
      req_tdata     <= '0;
      rsp_tready    <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_values();
      test_random_numbers(21, 72, 135);
      test_random_numbers(72, 21, 135);
      test_random_numbers(0, 0, 135);
      test_drain_between_numbers(10);

      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d numbers into %0d checked characters", numbers_sent,
               chars_checked);
      $display("Modes: %0d signed dec, %0d unsigned dec, %0d octal, %0d hex; %0d errors",
               mode_count[MODE_SDEC], mode_count[MODE_UDEC], mode_count[MODE_OCT],
               mode_count[MODE_HEX], error_count);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
